### rtl/core/uvsph_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uvsph_pkg;

    // Widths of the register data, register index and result fields
    localparam int CFG_W = 11;
    localparam int IDX_W = 2;
    localparam int OUT_W = 20;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_LAT_LINES  = 2'd0;
    localparam logic [IDX_W-1:0] REG_LONG_LINES = 2'd1;
    localparam logic [IDX_W-1:0] REG_CLOCKWISE  = 2'd2;

    // Smallest and largest usable line count on either axis
    localparam int MIN_LINES = 3;
    localparam int MAX_LINES = 1024;

    // Mesh sections
    typedef logic [1:0] section_t;
    localparam section_t SEC_TOP    = 2'd0;
    localparam section_t SEC_BODY   = 2'd1;
    localparam section_t SEC_BOTTOM = 2'd2;

endpackage

`default_nettype wire

### rtl/core/uv_sphere_triangle_index_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Triangle index generator for a latitude/longitude sphere mesh. Each accepted
// input item yields one result item holding the three vertex indices of the
// next triangle: first a fan of long_lines triangles around the top pole
// (vertex 0), then two triangles per quad for each of the lat_lines-3 body
// rows including the seam quad, then a fan around the bottom pole (vertex
// (lat_lines-2)*long_lines+1), after which the sequence starts over. mesh_last
// marks the final triangle. restart=1 emits the first triangle. clockwise=1
// swaps corners b and c. Line counts are clamped to 3..MAX_LINES at write
// time; writing any of the three registers returns the sequence to the first
// triangle. One item per clock while results are taken: the triangle is
// formed from the sequence counters in the accepting cycle and held in the
// output register, which refills in the same cycle the previous item is taken.
module uv_sphere_triangle_index_generator_top (
    input  wire                          clk,
    input  wire                          rst_n,
    // register write port
    input  wire                          cfg_wr_en,
    input  wire [uvsph_pkg::IDX_W-1:0]   cfg_index,
    input  wire [uvsph_pkg::CFG_W-1:0]   cfg_data,
    // input channel
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          restart,
    // result channel
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [uvsph_pkg::OUT_W-1:0]  corner_a,
    output logic [uvsph_pkg::OUT_W-1:0]  corner_b,
    output logic [uvsph_pkg::OUT_W-1:0]  corner_c,
    output logic                         mesh_last
);

    import uvsph_pkg::*;

    // line count width, counter width, arithmetic width, compare width
    localparam int LW  = $clog2(MAX_LINES + 1);
    localparam int CNW = $clog2(MAX_LINES);
    localparam int AW  = (2 * LW > OUT_W) ? 2 * LW : OUT_W;
    localparam int CMW = (LW > CFG_W) ? LW : CFG_W;

    localparam logic [CMW-1:0] MIN_C = CMW'(MIN_LINES);
    localparam logic [CMW-1:0] MAX_C = CMW'(MAX_LINES);

    // configuration
    logic [LW-1:0]  lat_reg;
    logic [LW-1:0]  long_reg;
    logic           cw_reg;
    logic [CMW-1:0] cfg_wide;
    logic [LW-1:0]  cfg_clamped;
    logic           cfg_hit;

    // sequence state
    section_t       section_reg, section_next;
    logic [CNW-1:0] row_reg, row_next;
    logic [CNW-1:0] col_reg, col_next;
    logic           half_reg, half_next;
    logic [AW-1:0]  base_reg, base_next;

    // result register
    logic             out_valid_reg;
    logic [OUT_W-1:0] a_reg, b_reg, c_reg;
    logic             last_reg;

    // working values
    section_t       sec;
    logic [CNW-1:0] col, row;
    logic           half;
    logic [AW-1:0]  base;
    logic [AW-1:0]  nr_w, nl_w, nv_w, col_w, row_w;
    logic [AW-1:0]  up_l, up_r, dn_l, dn_r;
    logic [AW-1:0]  va, vb, vd;
    logic           col_last;
    logic           last;
    logic           in_acc;

    // clamp write data to the usable line range
    assign cfg_wide    = CMW'(cfg_data);
    assign cfg_clamped = (cfg_wide < MIN_C) ? LW'(MIN_C) :
                         (cfg_wide > MAX_C) ? LW'(MAX_C) : LW'(cfg_wide);
    assign cfg_hit     = cfg_wr_en && ((cfg_index == REG_LAT_LINES) ||
                                       (cfg_index == REG_LONG_LINES) ||
                                       (cfg_index == REG_CLOCKWISE));

    assign in_ready = !out_valid_reg || out_ready;
    assign in_acc   = in_valid && in_ready;

    // form the triangle and the next sequence position
    always_comb
    begin
        sec  = restart ? SEC_TOP : section_reg;
        col  = restart ? '0 : col_reg;
        row  = restart ? '0 : row_reg;
        half = restart ? 1'b0 : half_reg;
        base = restart ? '0 : base_reg;

        nr_w  = AW'(lat_reg);
        nl_w  = AW'(long_reg);
        nv_w  = AW'((nr_w - AW'(2)) * nl_w) + AW'(2);
        col_w = AW'(col);
        row_w = AW'(row);

        col_last = !((col_w + AW'(1)) < nl_w);

        up_l = base + col_w + AW'(1);
        dn_l = base + nl_w + col_w + AW'(1);
        up_r = col_last ? base + AW'(1) : up_l + AW'(1);
        dn_r = col_last ? base + nl_w + AW'(1) : dn_l + AW'(1);

        last = 1'b0;
        va   = '0;
        vb   = '0;
        vd   = '0;

        section_next = sec;
        col_next     = col;
        row_next     = row;
        half_next    = half;
        base_next    = base;

        case (sec)
            SEC_BODY:
            begin
                if (!half)
                begin
                    va = up_l;
                    vb = up_r;
                    vd = dn_l;
                    half_next = 1'b1;
                end
                else
                begin
                    va = dn_l;
                    vb = up_r;
                    vd = dn_r;
                    half_next = 1'b0;
                    if (!col_last)
                    begin
                        col_next = col + CNW'(1);
                    end
                    else
                    begin
                        col_next = '0;
                        if ((row_w + AW'(4)) < nr_w)
                        begin
                            row_next  = row + CNW'(1);
                            base_next = base + nl_w;
                        end
                        else
                        begin
                            section_next = SEC_BOTTOM;
                        end
                    end
                end
            end
            SEC_BOTTOM:
            begin
                va = nv_w - AW'(1);
                if (!col_last)
                begin
                    vb = nv_w - AW'(3) - col_w;
                    vd = nv_w - AW'(2) - col_w;
                    col_next = col + CNW'(1);
                end
                else
                begin
                    vb   = nv_w - AW'(2);
                    vd   = nv_w - AW'(1) - nl_w;
                    last = 1'b1;
                    section_next = SEC_TOP;
                    col_next     = '0;
                    row_next     = '0;
                    half_next    = 1'b0;
                    base_next    = '0;
                end
            end
            default:
            begin
                // top cap; the unused code behaves the same
                va = '0;
                section_next = SEC_TOP;
                if (!col_last)
                begin
                    vb = col_w + AW'(2);
                    vd = col_w + AW'(1);
                    col_next = col + CNW'(1);
                end
                else
                begin
                    vb = AW'(1);
                    vd = nl_w;
                    col_next  = '0;
                    row_next  = '0;
                    half_next = 1'b0;
                    base_next = '0;
                    section_next = (nr_w > AW'(MIN_LINES)) ? SEC_BODY : SEC_BOTTOM;
                end
            end
        endcase
    end

    // hold configuration and sequence position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg     <= LW'(MIN_LINES);
            long_reg    <= LW'(MIN_LINES);
            cw_reg      <= 1'b0;
            section_reg <= SEC_TOP;
            row_reg     <= '0;
            col_reg     <= '0;
            half_reg    <= 1'b0;
            base_reg    <= '0;
        end
        else if (cfg_hit)
        begin
            case (cfg_index)
                REG_LAT_LINES:  lat_reg  <= cfg_clamped;
                REG_LONG_LINES: long_reg <= cfg_clamped;
                default:        cw_reg   <= cfg_data[0];
            endcase
            section_reg <= SEC_TOP;
            row_reg     <= '0;
            col_reg     <= '0;
            half_reg    <= 1'b0;
            base_reg    <= '0;
        end
        else if (in_acc)
        begin
            section_reg <= section_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            half_reg    <= half_next;
            base_reg    <= base_next;
        end
    end

    // advance the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // load the result item, applying the winding swap
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_reg    <= va[OUT_W-1:0];
            b_reg    <= cw_reg ? vd[OUT_W-1:0] : vb[OUT_W-1:0];
            c_reg    <= cw_reg ? vb[OUT_W-1:0] : vd[OUT_W-1:0];
            last_reg <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign corner_a  = a_reg;
    assign corner_b  = b_reg;
    assign corner_c  = c_reg;
    assign mesh_last = last_reg;

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import uvsph_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [OUT_W-1:0] a;
        logic [OUT_W-1:0] b;
        logic [OUT_W-1:0] c;
        logic             last;
    } tri_t;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] data;
        logic             rs;
        logic             typed;
        tri_t             want;
    } row_t;

    localparam int DIR_N = 25;
    localparam tri_t NO_TRI = '0;

    // Directed rows: defaults first, then restart, winding, clamping and rewind on write
    localparam row_t DIR_ROWS [DIR_N] = '{
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b0, 1'b1, '{20'd0, 20'd2, 20'd1, 1'b0}},
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b0, 1'b1, '{20'd0, 20'd3, 20'd2, 1'b0}},
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b0, 1'b1, '{20'd0, 20'd1, 20'd3, 1'b0}},
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b0, 1'b1, '{20'd4, 20'd2, 20'd3, 1'b0}},
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b0, 1'b1, '{20'd4, 20'd1, 20'd2, 1'b0}},
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b0, 1'b1, '{20'd4, 20'd3, 20'd1, 1'b1}},
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b0, 1'b1, '{20'd0, 20'd2, 20'd1, 1'b0}},
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b1, 1'b1, '{20'd0, 20'd2, 20'd1, 1'b0}},
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b0, 1'b1, '{20'd0, 20'd3, 20'd2, 1'b0}},
        '{ROW_WRITE, REG_CLOCKWISE,  11'd1,    1'b0, 1'b0, NO_TRI},
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b0, 1'b1, '{20'd0, 20'd1, 20'd2, 1'b0}},
        '{ROW_WRITE, REG_LAT_LINES,  11'd4,    1'b0, 1'b0, NO_TRI},
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b0, 1'b0, NO_TRI},
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b0, 1'b0, NO_TRI},
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b0, 1'b0, NO_TRI},
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b1, 1'b0, NO_TRI},
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b0, 1'b0, NO_TRI},
        '{ROW_WRITE, REG_LAT_LINES,  11'd0,    1'b0, 1'b0, NO_TRI},
        '{ROW_WRITE, REG_LONG_LINES, 11'd1,    1'b0, 1'b0, NO_TRI},
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b0, 1'b1, '{20'd0, 20'd1, 20'd2, 1'b0}},
        '{ROW_WRITE, REG_LAT_LINES,  11'd2047, 1'b0, 1'b0, NO_TRI},
        '{ROW_WRITE, REG_LONG_LINES, 11'd2047, 1'b0, 1'b0, NO_TRI},
        '{ROW_WRITE, REG_CLOCKWISE,  11'd0,    1'b0, 1'b0, NO_TRI},
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b0, 1'b1, '{20'd0, 20'd2, 20'd1, 1'b0}},
        '{ROW_ITEM,  REG_LAT_LINES,  11'd0,    1'b0, 1'b0, NO_TRI}
    };

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic             restart   = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [OUT_W-1:0] corner_a;
    logic [OUT_W-1:0] corner_b;
    logic [OUT_W-1:0] corner_c;
    logic             mesh_last;

    // Mesh geometry and sequence counters as the block should hold them
    logic [CFG_W-1:0] lat_q;
    logic [CFG_W-1:0] long_q;
    logic             cw_q;
    section_t         sec_q;
    logic [9:0]       row_q;
    logic [9:0]       col_q;
    logic             half_q;
    logic [20:0]      base_q;

    tri_t pending_tris [$];
    int   mismatch_count = 0;
    int   results_taken  = 0;
    int   rx_stall_pct   = 0;
    bit   calm           = 1'b0;
    bit   held_once      = 1'b0;

    uv_sphere_triangle_index_generator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .corner_a  (corner_a),
        .corner_b  (corner_b),
        .corner_c  (corner_c),
        .mesh_last (mesh_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int unsigned clamp_lines(input logic [CFG_W-1:0] v);
        if (v < MIN_LINES)
            return MIN_LINES;
        if (v > MAX_LINES)
            return MAX_LINES;
        return 32'(v);
    endfunction

    // Return the counters to the first triangle of the mesh
    function automatic void rewind_mesh();
        sec_q  = SEC_TOP;
        row_q  = '0;
        col_q  = '0;
        half_q = 1'b0;
        base_q = '0;
    endfunction

    // Form the next triangle from the counters, then advance them
    function automatic tri_t next_triangle(input logic rs);
        int unsigned nr, nl, nv, c, a, b, d, t, up_l, up_r, dn_l, dn_r;
        tri_t        r;
        nr = clamp_lines(lat_q);
        nl = clamp_lines(long_q);
        nv = (nr - 2) * nl + 2;
        if (rs)
            rewind_mesh();
        c = 32'(col_q);
        r.last = 1'b0;

        case (sec_q)
            SEC_BODY:
            begin
                up_l = base_q + c + 1;
                dn_l = base_q + nl + c + 1;
                if (c + 1 < nl)
                begin
                    up_r = up_l + 1;
                    dn_r = dn_l + 1;
                end
                else
                begin
                    up_r = base_q + 1;
                    dn_r = base_q + nl + 1;
                end
                if (!half_q)
                begin
                    a = up_l; b = up_r; d = dn_l;
                end
                else
                begin
                    a = dn_l; b = up_r; d = dn_r;
                end
            end
            SEC_BOTTOM:
            begin
                a = nv - 1;
                if (c + 1 < nl)
                begin
                    b = nv - 3 - c;
                    d = nv - 2 - c;
                end
                else
                begin
                    b = nv - 2;
                    d = nv - 1 - nl;
                    r.last = 1'b1;
                end
            end
            default:
            begin
                a = 0;
                if (c + 1 < nl)
                begin
                    b = c + 2; d = c + 1;
                end
                else
                begin
                    b = 1; d = nl;
                end
            end
        endcase

        if (cw_q)
        begin
            t = b; b = d; d = t;
        end
        r.a = a[OUT_W-1:0];
        r.b = b[OUT_W-1:0];
        r.c = d[OUT_W-1:0];

        // Advance the counters
        case (sec_q)
            SEC_BODY:
            begin
                if (!half_q)
                    half_q = 1'b1;
                else
                begin
                    half_q = 1'b0;
                    if (c + 1 < nl)
                        col_q = 10'(c + 1);
                    else
                    begin
                        col_q = '0;
                        if (row_q + 4 < nr)
                        begin
                            row_q  = 10'(row_q + 1);
                            base_q = 21'(base_q + nl);
                        end
                        else
                            sec_q = SEC_BOTTOM;
                    end
                end
            end
            SEC_BOTTOM:
            begin
                if (c + 1 < nl)
                    col_q = 10'(c + 1);
                else
                    rewind_mesh();
            end
            default:
            begin
                if (c + 1 < nl)
                begin
                    col_q = 10'(c + 1);
                    sec_q = SEC_TOP;
                end
                else
                begin
                    col_q  = '0;
                    row_q  = '0;
                    base_q = '0;
                    half_q = 1'b0;
                    sec_q  = (nr > 3) ? SEC_BODY : SEC_BOTTOM;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        $display("mismatch at %0t: %s got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Hold valid and payload until the item is taken, then queue its triangle
    task automatic offer_item(input logic rs, input logic typed, input tri_t want);
        tri_t model;
        in_valid  <= 1'b1;
        restart   <= rs;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        model = next_triangle(rs);
        pending_tris.insert(pending_tris.size(), typed ? want : model);
    endtask

    // Drop valid and wait until every queued triangle has come out
    task automatic drain_items();
        in_valid <= 1'b0;
        while (pending_tris.size() != 0)
            @(posedge clk);
    endtask

    // Write one register; the enable is dropped by the next item or gap
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_LAT_LINES:  begin lat_q  = data;    rewind_mesh(); end
            REG_LONG_LINES: begin long_q = data;    rewind_mesh(); end
            REG_CLOCKWISE:  begin cw_q   = data[0]; rewind_mesh(); end
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] lat, input logic [CFG_W-1:0] lng,
                             input logic cw, input int items, input int restart_pct,
                             input int tx_pct, input int rx_pct, input bit mid_pause,
                             input bit unused_wr);
        drain_items();
        rx_stall_pct = rx_pct;
        write_reg(REG_LAT_LINES, lat);
        write_reg(REG_LONG_LINES, lng);
        write_reg(REG_CLOCKWISE, CFG_W'(cw));
        for (int i = 0; i < items; i++)
        begin
            // Pause mid-phase until the block is empty
            if (mid_pause && i == items / 2)
            begin
                drain_items();
                if (unused_wr)
                    write_reg(REG_UNUSED, CFG_W'($urandom));
            end
            if (!calm && $urandom_range(0, 99) < tx_pct)
            begin
                in_valid  <= 1'b0;
                cfg_wr_en <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            offer_item($urandom_range(0, 99) < restart_pct, 1'b0, NO_TRI);
        end
    endtask

    // Stimulus: reset, directed table, then phases of random items
    initial
    begin
        lat_q  = MIN_LINES;
        long_q = MIN_LINES;
        cw_q   = 1'b0;
        rewind_mesh();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            if (DIR_ROWS[i].kind == ROW_WRITE)
            begin
                drain_items();
                write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].data);
            end
            else
                offer_item(DIR_ROWS[i].rs, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end

        run_phase(11'd1024, 11'd1024, 1'b1, 60, 10, 20, 20, 1'b0, 1'b0);
        run_phase(11'd3, 11'd1024, 1'b0, 1030, 0, 10, 10, 1'b1, 1'b0);
        run_phase(11'd1024, 11'd3, 1'b1, 80, 0, 30, 30, 1'b1, 1'b1);
        run_phase(11'd2, 11'd0, 1'b0, 40, 0, 0, 0, 1'b0, 1'b0);
        for (int p = 0; p < 8; p++)
        begin
            if (p == 7)
                calm = 1'b1;
            run_phase(CFG_W'($urandom_range(0, 9)), CFG_W'($urandom_range(0, 9)),
                      1'($urandom_range(0, 1)), $urandom_range(30, 90),
                      $urandom_range(0, 4), $urandom_range(0, 2) * 20,
                      $urandom_range(0, 2) * 20, p[0], 1'b0);
        end

        drain_items();
        repeat (5) @(posedge clk);
        if (mismatch_count == 0 && pending_tris.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result side: random stalls, one long hold-off, none in the calm tail
    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held_once && results_taken >= 400 && in_valid)
            begin
                held_once = 1'b1;
                out_ready <= 1'b0;
                for (int n = 0; n < 60; n++)
                    @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 99) < rx_stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each taken result with the oldest queued triangle
    always @(posedge clk)
    begin
        tri_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_taken++;
            if (pending_tris.size() == 0)
            begin
                $display("unexpected result at %0t: %0d %0d %0d last %0b",
                         $realtime, corner_a, corner_b, corner_c, mesh_last);
                mismatch_count++;
            end
            else
            begin
                want = pending_tris.pop_front();
                if (corner_a !== want.a)
                    report_mismatch("corner_a", corner_a, want.a);
                if (corner_b !== want.b)
                    report_mismatch("corner_b", corner_b, want.b);
                if (corner_c !== want.c)
                    report_mismatch("corner_c", corner_c, want.c);
                if (mesh_last !== want.last)
                    report_mismatch("mesh_last", OUT_W'(mesh_last), OUT_W'(want.last));
            end
        end
    end

endmodule
